// ===== rtl/llt_pkg.sv =====
// ----------------------------------------------------------------------------
// llt_pkg
// Shared types, codes and score packing functions for the transposition table.
// ----------------------------------------------------------------------------
package llt_pkg;

  localparam int ENTRIES   = 4096;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int DATA_W    = 58;
  localparam int CHECK_W   = 64;
  localparam int ROW_W     = CHECK_W + DATA_W;
  localparam int KEY_W     = 64;
  localparam int MOVE_W    = 28;
  localparam int OSCORE_W  = 19;
  localparam int SC_W      = 20;
  localparam int IN_DATA_W = 168;
  localparam int OUT_DATA_W = 48;

  localparam logic [15:0]       MATE_THR_RST = 16'd48000;
  localparam logic [IDX_W-1:0]  CLR_LAST     = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_MISS  = 2'd0,
    STAT_SCORE = 2'd1,
    STAT_STORE = 2'd2,
    STAT_CLEAR = 2'd3
  } status_t;

  localparam logic [3:0] FLAG_EXACT = 4'd0;
  localparam logic [3:0] FLAG_UPPER = 4'd1;
  localparam logic [3:0] FLAG_LOWER = 4'd2;

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_PROBE
  } state_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                key_match;
    logic [MOVE_W-1:0]   best_move;
    logic [OSCORE_W-1:0] score;
  } res_t;

  // store side: mate adjust away from zero, offset and pack
  function automatic logic [DATA_W-1:0] store_pack(
    input logic signed [16:0] value,
    input logic [5:0]         ply,
    input logic [7:0]         depth,
    input logic [27:0]        move,
    input logic [3:0]         flag,
    input logic [15:0]        m
  );
    logic signed [SC_W-1:0] s;
    logic signed [SC_W-1:0] pos_m;
    logic signed [SC_W-1:0] neg_m;
    logic signed [SC_W-1:0] ply_s;
    logic [SC_W-1:0]        enc;
    pos_m = $signed({4'd0, m});
    neg_m = -pos_m;
    ply_s = $signed({14'd0, ply});
    s = $signed({{3{value[16]}}, value});
    if (s < neg_m) s = s - ply_s;
    if (s > pos_m) s = s + ply_s;
    enc = s + 20'sd65000;
    return {flag, depth, enc[17:0], move};
  endfunction

  // probe side: check key, depth and bound rule
  function automatic res_t probe_eval(
    input logic [ROW_W-1:0]   row,
    input logic [KEY_W-1:0]   key,
    input logic [5:0]         ply,
    input logic signed [16:0] alpha,
    input logic signed [16:0] beta,
    input logic [7:0]         depth,
    input logic [15:0]        m
  );
    logic [DATA_W-1:0]      data;
    logic [CHECK_W-1:0]     check;
    logic signed [SC_W-1:0] s;
    logic signed [SC_W-1:0] pos_m;
    logic signed [SC_W-1:0] neg_m;
    logic signed [SC_W-1:0] ply_s;
    logic signed [SC_W-1:0] a_s;
    logic signed [SC_W-1:0] b_s;
    logic [3:0]             rflag;
    res_t                   r;
    data  = row[DATA_W-1:0];
    check = row[ROW_W-1:DATA_W];
    rflag = data[57:54];
    pos_m = $signed({4'd0, m});
    neg_m = -pos_m;
    ply_s = $signed({14'd0, ply});
    a_s   = $signed({{3{alpha[16]}}, alpha});
    b_s   = $signed({{3{beta[16]}}, beta});
    s     = $signed({2'b00, data[45:28]}) - 20'sd65000;
    r     = '0;
    r.status = STAT_MISS;
    if ((check ^ {6'd0, data}) == key) begin
      r.key_match = 1'b1;
      r.best_move = data[27:0];
      if (data[53:46] >= depth) begin
        if (s < neg_m) s = s + ply_s;
        if (s > pos_m) s = s - ply_s;
        if (rflag == FLAG_EXACT) begin
          r.status = STAT_SCORE;
          r.score  = s[OSCORE_W-1:0];
        end else if (rflag == FLAG_UPPER && s <= a_s) begin
          r.status = STAT_SCORE;
          r.score  = a_s[OSCORE_W-1:0];
        end else if (rflag == FLAG_LOWER && s >= b_s) begin
          r.status = STAT_SCORE;
          r.score  = b_s[OSCORE_W-1:0];
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/llt_ram.sv =====
// ----------------------------------------------------------------------------
// llt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module llt_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 122
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/llt_out_q.sv =====
// ----------------------------------------------------------------------------
// llt_out_q
// Two-entry result queue between the table control and the output stream.
// ----------------------------------------------------------------------------
module llt_out_q
  import llt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  res_t       buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count_r != 2'd0;
  assign full      = count_r == 2'd2;
  assign out_res   = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

// ===== rtl/llt_ctrl.sv =====
// ----------------------------------------------------------------------------
// llt_ctrl
// Table sequencer: probe read and evaluate, store write, clearing sweep.
// ----------------------------------------------------------------------------
module llt_ctrl
  import llt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [KEY_W-1:0]   key,
  input  logic [5:0]         ply,
  input  logic signed [16:0] alpha,
  input  logic signed [16:0] beta,
  input  logic [7:0]         depth,
  input  logic signed [16:0] value,
  input  logic [27:0]        move,
  input  logic [3:0]         bound_flag,
  input  logic               q_full,
  output logic               push,
  output res_t               push_res,
  output logic               mem_we,
  output logic [IDX_W-1:0]   mem_waddr,
  output logic [ROW_W-1:0]   mem_wdata,
  output logic               mem_re,
  output logic [IDX_W-1:0]   mem_raddr,
  input  logic [ROW_W-1:0]   mem_rdata
);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_ptr_r, clr_ptr_nxt;
  logic               clr_op_r, clr_op_nxt;
  logic [15:0]        mate_thr_r;
  logic [KEY_W-1:0]   key_r;
  logic [5:0]         ply_r;
  logic signed [16:0] alpha_r;
  logic signed [16:0] beta_r;
  logic [7:0]         depth_r;
  logic               accept;
  logic [DATA_W-1:0]  st_data;

  assign in_ready = (state_r == ST_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign st_data  = store_pack(value, ply, depth, move, bound_flag, mate_thr_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (clr_ptr_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && op == OP_PROBE) state_nxt = ST_PROBE;
        else if (accept && op == OP_CLEAR) state_nxt = ST_CLR;
      end
      ST_PROBE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    push        = 1'b0;
    push_res    = '0;
    mem_we      = 1'b0;
    mem_waddr   = key[IDX_W-1:0];
    mem_wdata   = {key ^ {6'd0, st_data}, st_data};
    mem_re      = 1'b0;
    mem_raddr   = key[IDX_W-1:0];
    clr_ptr_nxt = clr_ptr_r;
    clr_op_nxt  = clr_op_r;
    case (state_r)
      ST_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_ptr_r;
        mem_wdata   = '0;
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == CLR_LAST && clr_op_r) begin
          push            = 1'b1;
          push_res.status = STAT_CLEAR;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_PROBE: begin
              mem_re = 1'b1;
            end
            OP_STORE: begin
              mem_we          = 1'b1;
              push            = 1'b1;
              push_res.status = STAT_STORE;
            end
            OP_CLEAR: begin
              clr_ptr_nxt = '0;
              clr_op_nxt  = 1'b1;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      ST_PROBE: begin
        push     = 1'b1;
        push_res = probe_eval(mem_rdata, key_r, ply_r, alpha_r, beta_r, depth_r,
                              mate_thr_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_ptr_r  <= '0;
      clr_op_r   <= 1'b0;
      mate_thr_r <= MATE_THR_RST;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      clr_op_r  <= clr_op_nxt;
      if (cfg_we) mate_thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r   <= key;
      ply_r   <= ply;
      alpha_r <= alpha;
      beta_r  <= beta;
      depth_r <= depth;
    end
  end

endmodule

// ===== rtl/lockless_transposition_table.sv =====
// ----------------------------------------------------------------------------
// lockless_transposition_table
// Direct-mapped, xor-checked transposition table with mate score adjustment.
//
//   channel  dir  handshake         payload
//   in_      in   tvalid / tready   tuser: operation; tdata: probe/store fields
//   out_     out  tvalid / tready   tuser: status; tdata: match, move, score
//   cfg_     in   wr_en             wr_data: mate_threshold
//
// store: written at the accepting edge; unused op: a miss result is pushed, nothing written
// probe: the row is read through the registered RAM read port, then evaluated in ST_PROBE
// clear: all 4096 slots, one slot zeroed per cycle through the RAM write port
// after reset the same clearing pass runs with in_tready low
// a two-beat result queue lets input beats in while a result waits downstream
// ----------------------------------------------------------------------------
module lockless_transposition_table
  import llt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,   // mate_threshold
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // key, ply, alpha, beta, depth, value, move, bound_flag, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]            in_tuser,      // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // key_match, best_move, result_score
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser      // status
);

  logic             q_full;
  logic             push;
  res_t             push_res;
  res_t             out_res;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ROW_W-1:0] mem_rdata;

  llt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_wr_en),
    .cfg_data   (cfg_wr_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .op         (in_tuser),
    .key        (in_tdata[63:0]),
    .ply        (in_tdata[69:64]),
    .alpha      ($signed(in_tdata[86:70])),
    .beta       ($signed(in_tdata[103:87])),
    .depth      (in_tdata[111:104]),
    .value      ($signed(in_tdata[128:112])),
    .move       (in_tdata[156:129]),
    .bound_flag (in_tdata[160:157]),
    .q_full     (q_full),
    .push       (push),
    .push_res   (push_res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  llt_ram #(
    .ADDR_W (IDX_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  llt_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.status;
  assign out_tdata = {out_res.score, out_res.best_move, out_res.key_match};

endmodule

// ===== rtl/llt_checker.sv =====
// ----------------------------------------------------------------------------
// llt_checker
// Port-level checks on the transposition table, bound to the top level.
// ----------------------------------------------------------------------------
module llt_checker
  import llt_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [1:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during clearing pass after reset");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_PROBE || in_tuser == OP_CLEAR)
    |=> !in_tready)
    else $error("input ready while probe or clear in progress");

  a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_STORE || out_tuser == STAT_CLEAR)
    |-> out_tdata == '0)
    else $error("store or clear beat carries nonzero payload");

  a_miss_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_MISS |-> out_tdata[47:29] == '0)
    else $error("score present without usable entry");

endmodule

bind lockless_transposition_table llt_checker u_llt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
